### hdl/tpa_pkg.sv
// Package: shared types, constants and state codes for the page allocator.
`timescale 1ns / 1ps
package tpa_pkg;

    localparam int DEF_MAX_TABLES          = 16;
    localparam int DEF_MAX_PAGES_PER_TABLE = 16;
    localparam int DEF_PAGE_BITS           = 18;

    localparam int CFG_W  = 5;
    localparam int CIDX_W = 1;

    localparam logic [CIDX_W-1:0] REG_TABLES = 1'd0;
    localparam logic [CIDX_W-1:0] REG_PAGES  = 1'd1;

    localparam logic [1:0] OP_ALLOC     = 2'd0;
    localparam logic [1:0] OP_DELETE    = 2'd1;
    localparam logic [1:0] OP_RELEASE   = 2'd2;
    localparam logic [1:0] OP_TRANSLATE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_PAGES = 3'd1;
    localparam logic [2:0] ST_NO_SLOT  = 3'd2;
    localparam logic [2:0] ST_UNMAPPED = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  slot_number;
        logic [21:0] byte_offset;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_number_out;
        logic [7:0]  page_number;
        logic [17:0] byte_in_page;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_REBUILD,
        S_IDLE,
        S_DECIDE,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_WR,
        S_XLATE_RD,
        S_XLATE_WR,
        S_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic rebuild_init;
        logic rebuild_step;
        logic capture;
        logic decide;
        logic pop_rd;
        logic alloc_wr;
        logic free_rd;
        logic free_wr;
        logic xlate_rd;
        logic xlate_wr;
        logic out_load;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic rebuild_done;
        logic go_alloc;
        logic go_free;
        logic go_xlate;
        logic walk_done;
        logic out_busy;
    } t_stat;

endpackage

### hdl/table_page_allocator_core.sv
// Top level: page allocator with free stack and page table.
// Allocate decodes, then per page reads the free stack and writes the page
// map; delete and release walk the page map, then give one result; translate
// reads the page map once, then gives its result. Transactions are handled
// one at a time, each page step being a read state then a write state.
// Reset and every register write rebuild the free stack.
`timescale 1ns / 1ps
module table_page_allocator_core
    import tpa_pkg::*;
#(
    parameter int MAX_TABLES          = DEF_MAX_TABLES,
    parameter int MAX_PAGES_PER_TABLE = DEF_MAX_PAGES_PER_TABLE,
    parameter int PAGE_BITS           = DEF_PAGE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    assign o_in_stall = !w_ready;

    tpa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_hit (i_cfg_we),
        .i_in_acc  (i_in_valid && w_ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_in_ready(w_ready)
    );

    tpa_dpath #(
        .MAX_TABLES         (MAX_TABLES),
        .MAX_PAGES_PER_TABLE(MAX_PAGES_PER_TABLE),
        .PAGE_BITS          (PAGE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .o_stat     (w_stat),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule

### hdl/tpa_ctrl.sv
// Controller: sequences rebuild, allocate, free walks and translate.
`timescale 1ns / 1ps
module tpa_ctrl
    import tpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_hit,
    input  logic  i_in_acc,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);

    t_state r_state, n_state;

    // Advance the state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_REBUILD;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_REBUILD:  if (i_stat.rebuild_done) n_state = S_IDLE;
            S_IDLE:     if (i_in_acc) n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.go_alloc) n_state = S_ALLOC_RD;
                else if (i_stat.go_free) n_state = S_FREE_RD;
                else if (i_stat.go_xlate) n_state = S_XLATE_RD;
                else n_state = S_OUT;
            end
            S_ALLOC_RD: if (!i_stat.out_busy) n_state = S_ALLOC_WR;
            S_ALLOC_WR: n_state = i_stat.walk_done ? S_IDLE : S_ALLOC_RD;
            S_FREE_RD:  n_state = S_FREE_WR;
            S_FREE_WR:  n_state = i_stat.walk_done ? S_OUT : S_FREE_RD;
            S_XLATE_RD: n_state = S_XLATE_WR;
            S_XLATE_WR: n_state = S_OUT;
            S_OUT:      if (!i_stat.out_busy) n_state = S_IDLE;
            default:    n_state = S_REBUILD;
        endcase
        if (i_cfg_hit) n_state = S_REBUILD;
    end

    // Drive commands for the current state.
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_REBUILD:  o_cmd.rebuild_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.capture = i_in_acc;
            end
            S_DECIDE:   o_cmd.decide = 1'b1;
            S_ALLOC_RD: o_cmd.pop_rd = !i_stat.out_busy;
            S_ALLOC_WR: o_cmd.alloc_wr = 1'b1;
            S_FREE_RD:  o_cmd.free_rd = 1'b1;
            S_FREE_WR:  o_cmd.free_wr = 1'b1;
            S_XLATE_RD: o_cmd.xlate_rd = 1'b1;
            S_XLATE_WR: o_cmd.xlate_wr = 1'b1;
            S_OUT:      o_cmd.out_load = !i_stat.out_busy;
            default:    o_cmd = '0;
        endcase
        o_cmd.rebuild_init = i_cfg_hit;
    end

endmodule

### hdl/tpa_dpath.sv
// Datapath: free stack, page map, slot flags, registers and output stage.
`timescale 1ns / 1ps
module tpa_dpath
    import tpa_pkg::*;
#(
    parameter int MAX_TABLES          = DEF_MAX_TABLES,
    parameter int MAX_PAGES_PER_TABLE = DEF_MAX_PAGES_PER_TABLE,
    parameter int PAGE_BITS           = DEF_PAGE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_data,
    input  logic      i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int POOL   = MAX_TABLES * MAX_PAGES_PER_TABLE;
    localparam int PW     = $clog2(POOL) > 0 ? $clog2(POOL) : 1;
    localparam int CW     = $clog2(POOL + 1);
    localparam int SW     = $clog2(MAX_TABLES) > 0 ? $clog2(MAX_TABLES) : 1;
    localparam int JW     = $clog2(MAX_PAGES_PER_TABLE) > 0 ? $clog2(MAX_PAGES_PER_TABLE) : 1;
    localparam int JCW    = $clog2(MAX_PAGES_PER_TABLE + 1);

    logic [PW-1:0] r_stack [POOL];
    logic [PW-1:0] r_map   [POOL];
    logic [POOL-1:0] r_mapped;
    logic [MAX_TABLES-1:0] r_used;
    logic [CFG_W-1:0] r_tables, r_pages;
    logic [CW-1:0] r_count, r_ridx;
    logic [CW-1:0] r_pool;
    t_in_item r_in;
    logic [SW-1:0] r_slot;
    logic [JCW-1:0] r_j, r_lim;
    logic [PW-1:0] r_rd_stack, r_rd_map;
    logic r_rd_mapped;
    logic [2:0] r_status;
    logic r_out_valid;
    t_out_item r_out;

    logic [CFG_W-1:0] w_clamp;
    logic [CW-1:0] w_need;
    logic w_slot_free;
    logic [SW-1:0] w_low;
    logic [JW-1:0] w_j;
    logic [PW-1:0] w_ent;
    logic [21:0] w_pidx;
    logic w_out_busy;
    logic [PAGE_BITS-1:0] w_poff;

    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_need = CW'(r_pages);
    assign w_j = r_j[JW-1:0];
    assign w_ent = PW'(r_slot) * PW'(MAX_PAGES_PER_TABLE) + PW'(w_j);
    assign w_pidx = 22'(r_in.byte_offset >> PAGE_BITS);
    assign w_poff = r_in.byte_offset[PAGE_BITS-1:0];

    // Clamp the write data into the legal register range.
    always_comb begin
        logic [CFG_W-1:0] hi;
        hi = (i_cfg_idx == REG_TABLES) ? CFG_W'(MAX_TABLES) : CFG_W'(MAX_PAGES_PER_TABLE);
        if (i_cfg_data == '0) w_clamp = CFG_W'(1);
        else if (i_cfg_data > hi) w_clamp = hi;
        else w_clamp = i_cfg_data;
    end

    // Find the lowest free slot below tables_in_use.
    always_comb begin
        w_slot_free = 1'b0;
        w_low = '0;
        for (int s = MAX_TABLES - 1; s >= 0; s--) begin
            if (!r_used[s] && (CFG_W'(s) < r_tables)) begin
                w_slot_free = 1'b1;
                w_low = SW'(s);
            end
        end
    end

    // Configuration registers: tables and pages per table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tables <= CFG_W'(MAX_TABLES > 16 ? 16 : MAX_TABLES);
            r_pages  <= CFG_W'(MAX_PAGES_PER_TABLE > 16 ? 16 : MAX_PAGES_PER_TABLE);
        end else if (i_cfg_we && i_cfg_idx == REG_TABLES) begin
            r_tables <= w_clamp;
        end else if (i_cfg_we && i_cfg_idx == REG_PAGES) begin
            r_pages <= w_clamp;
        end
    end

    // Control state: count, flags, walk counters, output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rebuild_init) begin
            r_count <= '0;
            r_ridx <= '0;
            r_pool <= '0;
            r_used <= '0;
            r_mapped <= '0;
            r_j <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.rebuild_step) begin
                if (r_pool == '0) begin
                    r_pool <= CW'(r_tables) * CW'(r_pages);
                end else if (r_ridx != r_pool) begin
                    r_ridx <= r_ridx + 1'b1;
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.capture) begin
                r_in <= i_in_data;
                r_j <= '0;
            end
            if (i_cmd.decide) begin
                r_status <= ST_OK;
                r_slot <= SW'(r_in.slot_number);
                if (r_in.operation == OP_ALLOC) begin
                    r_lim <= JCW'(r_pages);
                    if (r_count < w_need) r_status <= ST_NO_PAGES;
                    else if (!w_slot_free) r_status <= ST_NO_SLOT;
                    else begin
                        r_slot <= w_low;
                        r_used[w_low] <= 1'b1;
                    end
                end else if (CFG_W'(r_in.slot_number) >= r_tables) begin
                    r_status <= ST_RANGE;
                end else if (r_in.operation == OP_DELETE) begin
                    r_lim <= JCW'(r_pages);
                    r_used[SW'(r_in.slot_number)] <= 1'b0;
                end else if (r_in.operation == OP_RELEASE) begin
                    r_lim <= (w_pidx < 22'(r_pages)) ? JCW'(w_pidx) : JCW'(r_pages);
                end else if (w_pidx >= 22'(r_pages)) begin
                    r_status <= ST_UNMAPPED;
                end
            end
            if (i_cmd.pop_rd) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.alloc_wr) begin
                r_mapped[w_ent] <= 1'b1;
                r_j <= r_j + 1'b1;
                r_out_valid <= 1'b1;
                r_out.status <= ST_OK;
                r_out.slot_number_out <= 4'(r_slot);
                r_out.page_number <= 8'(r_rd_stack);
                r_out.byte_in_page <= '0;
                r_out.last <= (r_j + 1'b1 == r_lim);
            end
            if (i_cmd.free_wr) begin
                r_j <= r_j + 1'b1;
                if (r_rd_mapped && r_count < CW'(POOL)) begin
                    r_count <= r_count + 1'b1;
                    r_mapped[w_ent] <= 1'b0;
                end
            end
            if (i_cmd.xlate_wr) begin
                if (!r_rd_mapped) r_status <= ST_UNMAPPED;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out.status <= r_status;
                r_out.slot_number_out <= (r_in.operation == OP_ALLOC) ? 4'd0 : r_in.slot_number;
                r_out.page_number <= (r_status == ST_OK && r_in.operation == OP_TRANSLATE)
                                     ? 8'(r_rd_map) : 8'd0;
                r_out.byte_in_page <= (r_status == ST_OK && r_in.operation == OP_TRANSLATE)
                                      ? 18'(w_poff) : 18'd0;
                r_out.last <= 1'b1;
            end
        end
    end

    // Free stack memory: rebuild fill, pop read, push write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rebuild_step && r_pool != '0 && r_ridx != r_pool) begin
            r_stack[r_ridx[PW-1:0]] <= PW'(r_pool - r_ridx - 1'b1);
        end else if (i_cmd.free_wr && r_rd_mapped && r_count < CW'(POOL)) begin
            r_stack[r_count[PW-1:0]] <= r_rd_map;
        end
        if (i_cmd.pop_rd) r_rd_stack <= r_stack[PW'(r_count - 1'b1)];
    end

    // Page map memory: write on allocate, read on free and translate.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_wr) r_map[w_ent] <= r_rd_stack;
        if (i_cmd.free_rd) begin
            r_rd_map <= r_map[w_ent];
            r_rd_mapped <= r_mapped[w_ent];
        end else if (i_cmd.xlate_rd) begin
            r_rd_map <= r_map[PW'(r_slot) * PW'(MAX_PAGES_PER_TABLE) + PW'(w_pidx)];
            r_rd_mapped <= r_mapped[PW'(r_slot) * PW'(MAX_PAGES_PER_TABLE) + PW'(w_pidx)];
        end
    end

    assign o_stat.rebuild_done = (r_pool != '0) && (r_ridx == r_pool);
    assign o_stat.go_alloc = (r_in.operation == OP_ALLOC) && (r_count >= w_need) && w_slot_free;
    assign o_stat.go_free = (CFG_W'(r_in.slot_number) < r_tables)
                            && (r_in.operation == OP_DELETE || r_in.operation == OP_RELEASE)
                            && ((r_in.operation == OP_DELETE) || (w_pidx != '0));
    assign o_stat.go_xlate = (r_in.operation == OP_TRANSLATE)
                             && (CFG_W'(r_in.slot_number) < r_tables)
                             && (w_pidx < 22'(r_pages));
    assign o_stat.walk_done = (r_j + 1'b1 == r_lim);
    assign o_stat.out_busy = w_out_busy;

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

### hdl/tpa_checker.sv
// Checker: port-level properties of the page allocator, bound to the top.
`timescale 1ns / 1ps
module tpa_checker
    import tpa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      i_in_valid,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A stalled result holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Status stays within its codes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_RANGE)
        else $error("bad status");

    // Failure results are marked last.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.last)
        else $error("failure not last");

    // Input is refused once reset has been sampled.
    assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("ready after reset");

    // An accepted transaction blocks the input for the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

endmodule

bind table_page_allocator_core tpa_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .i_in_valid (i_in_valid),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
